>>> rtl/bsp_pkg.sv
package bsp_pkg;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_BASE_EXPONENT = 2'd0,
    CFG_ROW_LENGTH    = 2'd1,
    CFG_ROW_COUNT     = 2'd2
  } cfg_index_t;

  localparam logic [3:0] GROUP_ESCAPE = 4'd0;
  localparam int         GROUP_MAX    = 15;

  typedef logic [15:0] bf16_t;

  function automatic logic [7:0] sign_mant_of(input bf16_t v);
    return {v[15], v[6:0]};
  endfunction

endpackage

>>> rtl/bf16_split12_packer.sv
// Channel   | Handshake               | Payload
// ----------+-------------------------+-----------------------------------------
// input     | in_valid / in_stall     | bf16_value
// result    | out_valid / out_stall   | sign_mant .. job_done (12 fields)
// config    | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// One transaction per cycle sustained while no result is stalled; each word passes
// through the input register, then the result register. Row, column and patch
// counters update when a word moves from the input register to the result register.
// Synchronous active-high reset clears valids and counters; config resets to base
// exponent 0, row length 1, row count 1. A stalled result freezes both stages;
// in_stall follows out_stall while a result is held. cfg_ready is always high.
module bf16_split12_packer
  import bsp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [15:0]            bf16_value,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [7:0]             sign_mant,
  output logic [3:0]             group,
  output logic [7:0]             group_byte,
  output logic                   group_byte_valid,
  output logic                   escape,
  output logic [15:0]            patch_column,
  output logic [31:0]            patch_index,
  output logic [15:0]            patch_orig,
  output logic [15:0]            patch_misread,
  output logic                   row_end,
  output logic [31:0]            row_offset,
  output logic                   job_done,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [8:0]  base_exponent;
  logic [15:0] row_length;
  logic [15:0] row_count;

  logic [15:0] column_counter, column_counter_next;
  logic [15:0] row_counter, row_counter_next;
  logic [31:0] patch_total, patch_total_next;
  logic [3:0]  pending_nibble, pending_nibble_next;
  logic        odd_position, odd_position_next;

  logic        s1_valid;
  bf16_t       s1_value;
  logic        advance;

  logic signed [9:0] diff;
  logic [3:0]  grp;
  logic        esc;
  logic        last_col;
  logic        last_row;
  logic [7:0]  gbyte;
  logic        gvalid;
  logic [31:0] total_inc;

  assign cfg_ready = 1'b1;
  assign advance   = !(out_valid && out_stall);
  assign in_stall  = !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_exponent <= '0;
      row_length    <= 16'd1;
      row_count     <= 16'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_BASE_EXPONENT: base_exponent <= cfg_data[8:0];
        CFG_ROW_LENGTH:    row_length    <= cfg_data;
        CFG_ROW_COUNT:     row_count     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    diff      = $signed({2'b00, s1_value[14:7]}) - $signed({base_exponent[8], base_exponent});
    esc       = !(diff >= 10'sd1 && diff <= 10'(GROUP_MAX));
    grp       = esc ? GROUP_ESCAPE : diff[3:0];
    last_col  = ({1'b0, column_counter} + 17'd1) >= {1'b0, row_length};
    last_row  = last_col && (({1'b0, row_counter} + 17'd1) >= {1'b0, row_count});
    total_inc = patch_total + 32'(esc);

    gbyte               = '0;
    gvalid              = 1'b0;
    pending_nibble_next = pending_nibble;
    odd_position_next   = odd_position;
    priority if (odd_position) begin
      gbyte               = {grp, pending_nibble};
      gvalid              = 1'b1;
      pending_nibble_next = '0;
      odd_position_next   = 1'b0;
    end else if (last_row) begin
      gbyte  = {4'd0, grp};
      gvalid = 1'b1;
    end else begin
      pending_nibble_next = grp;
      odd_position_next   = 1'b1;
    end

    column_counter_next = column_counter;
    row_counter_next    = row_counter;
    patch_total_next    = total_inc;
    priority if (last_row) begin
      column_counter_next = '0;
      row_counter_next    = '0;
      patch_total_next    = '0;
      pending_nibble_next = '0;
      odd_position_next   = 1'b0;
    end else if (last_col) begin
      column_counter_next = '0;
      row_counter_next    = row_counter + 16'd1;
    end else begin
      column_counter_next = column_counter + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid       <= 1'b0;
      out_valid      <= 1'b0;
      column_counter <= '0;
      row_counter    <= '0;
      patch_total    <= '0;
      pending_nibble <= '0;
      odd_position   <= 1'b0;
    end else if (advance) begin
      s1_valid  <= in_valid;
      out_valid <= s1_valid;
      if (s1_valid) begin
        column_counter <= column_counter_next;
        row_counter    <= row_counter_next;
        patch_total    <= patch_total_next;
        pending_nibble <= pending_nibble_next;
        odd_position   <= odd_position_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (in_valid) s1_value <= bf16_value;
      if (s1_valid) begin
        sign_mant        <= sign_mant_of(s1_value);
        group            <= grp;
        group_byte       <= gbyte;
        group_byte_valid <= gvalid;
        escape           <= esc;
        patch_column     <= esc ? column_counter : '0;
        patch_index      <= esc ? patch_total : '0;
        patch_orig       <= esc ? s1_value : '0;
        patch_misread    <= esc ? {s1_value[15] | base_exponent[8], base_exponent[7:0],
                                   s1_value[6:0]} : '0;
        row_end          <= last_col;
        row_offset       <= last_col ? total_inc : '0;
        job_done         <= last_row;
      end
    end
  end

endmodule

>>> rtl/bsp_checker.sv
module bsp_checker
  import bsp_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [3:0]  group,
  input logic [7:0]  group_byte,
  input logic        group_byte_valid,
  input logic        escape,
  input logic [15:0] patch_column,
  input logic [31:0] patch_index,
  input logic [15:0] patch_orig,
  input logic [15:0] patch_misread,
  input logic        row_end,
  input logic [31:0] row_offset,
  input logic        job_done
);

  a_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(group) && $stable(patch_index)
                               && $stable(row_offset))
    else $error("stalled transaction changed");

  a_escape_group: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (escape == (group == GROUP_ESCAPE)))
    else $error("escape flag disagrees with group");

  a_patch_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !escape |-> patch_column == '0 && patch_index == '0
                             && patch_orig == '0 && patch_misread == '0)
    else $error("patch fields set without escape");

  a_job_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && job_done |-> row_end && group_byte_valid)
    else $error("job end without row end or byte flush");

  a_row_offset: assert property (@(posedge clk) disable iff (rst)
    out_valid && (!row_end || !group_byte_valid) |->
      (row_end || row_offset == '0) && (group_byte_valid || group_byte == '0))
    else $error("row offset or group byte set while not valid");

endmodule

bind bf16_split12_packer bsp_checker u_bsp_checker (
  .clk              (clk),
  .rst              (rst),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .group            (group),
  .group_byte       (group_byte),
  .group_byte_valid (group_byte_valid),
  .escape           (escape),
  .patch_column     (patch_column),
  .patch_index      (patch_index),
  .patch_orig       (patch_orig),
  .patch_misread    (patch_misread),
  .row_end          (row_end),
  .row_offset       (row_offset),
  .job_done         (job_done)
);

>>> tb/bf16_split12_packer_tb.sv
`timescale 1ns / 100ps

module bf16_split12_packer_tb;
  import bsp_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int WORDS_PER_PHASE = 190;

  typedef struct packed {
    logic [7:0]  sign_mant;
    logic [3:0]  group;
    logic [7:0]  group_byte;
    logic        group_byte_valid;
    logic        escape;
    logic [15:0] patch_column;
    logic [31:0] patch_index;
    logic [15:0] patch_orig;
    logic [15:0] patch_misread;
    logic        row_end;
    logic [31:0] row_offset;
    logic        job_done;
  } pack_out_t;

  class pack_tracker;
    logic signed [8:0] base_reg = '0;
    logic [15:0] row_len = 16'd1;
    logic [15:0] row_total = 16'd1;
    logic [15:0] col_count = '0;
    logic [15:0] row_num = '0;
    logic [31:0] patch_count = '0;
    logic [3:0]  held_nibble = '0;
    logic        odd_pos = 1'b0;
    pack_out_t   expected_outputs[$];
    int mismatches = 0;
    int checked = 0;
    int words = 0;
    int patches = 0;
    int jobs = 0;
    int writes = 0;

    function void write_register(cfg_index_t idx, logic [15:0] data);
      case (idx)
        CFG_BASE_EXPONENT: base_reg = data[8:0];
        CFG_ROW_LENGTH:    row_len = data;
        CFG_ROW_COUNT:     row_total = data;
        default: ;
      endcase
      writes++;
    endfunction

    function void accept_word(bf16_t word);
      pack_out_t r;
      int diff;
      logic [3:0] grp;
      logic last_col;
      logic last_row;
      diff = int'(word[14:7]) - int'(base_reg);
      grp = (diff >= 1 && diff <= GROUP_MAX) ? diff[3:0] : GROUP_ESCAPE;
      last_col = ({16'd0, col_count} + 32'd1) >= {16'd0, row_len};
      last_row = last_col && (({16'd0, row_num} + 32'd1) >= {16'd0, row_total});
      r = '0;
      r.sign_mant = {word[15], word[6:0]};
      r.group = grp;
      if (odd_pos) begin
        r.group_byte = {grp, held_nibble};
        r.group_byte_valid = 1'b1;
        odd_pos = 1'b0;
        held_nibble = '0;
      end else if (last_row) begin
        r.group_byte = {4'd0, grp};
        r.group_byte_valid = 1'b1;
      end else begin
        held_nibble = grp;
        odd_pos = 1'b1;
      end
      if (grp == GROUP_ESCAPE) begin
        r.escape = 1'b1;
        r.patch_column = col_count;
        r.patch_index = patch_count;
        r.patch_orig = word;
        r.patch_misread = {word[15], 15'd0} | {base_reg, 7'd0} | {9'd0, word[6:0]};
        patch_count = patch_count + 32'd1;
        patches++;
      end
      if (last_col) begin
        r.row_end = 1'b1;
        r.row_offset = patch_count;
      end
      r.job_done = last_row;
      if (last_row) begin
        col_count = '0;
        row_num = '0;
        patch_count = '0;
        held_nibble = '0;
        odd_pos = 1'b0;
        jobs++;
      end else if (last_col) begin
        col_count = '0;
        row_num = row_num + 16'd1;
      end else begin
        col_count = col_count + 16'd1;
      end
      words++;
      expected_outputs.push_back(r);
    endfunction

    function void diff_field(string name, logic [31:0] e, logic [31:0] g, inout string bad);
      if (e !== g) bad = {bad, $sformatf(" %s exp %0h got %0h", name, e, g)};
    endfunction

    function void check_output(pack_out_t got);
      pack_out_t e;
      string bad;
      bad = "";
      checked++;
      if (expected_outputs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output %0d: %h", checked, got);
        return;
      end
      e = expected_outputs.pop_front();
      diff_field("sign_mant", e.sign_mant, got.sign_mant, bad);
      diff_field("group", e.group, got.group, bad);
      diff_field("group_byte", e.group_byte, got.group_byte, bad);
      diff_field("group_byte_valid", e.group_byte_valid, got.group_byte_valid, bad);
      diff_field("escape", e.escape, got.escape, bad);
      diff_field("patch_column", e.patch_column, got.patch_column, bad);
      diff_field("patch_index", e.patch_index, got.patch_index, bad);
      diff_field("patch_orig", e.patch_orig, got.patch_orig, bad);
      diff_field("patch_misread", e.patch_misread, got.patch_misread, bad);
      diff_field("row_end", e.row_end, got.row_end, bad);
      diff_field("row_offset", e.row_offset, got.row_offset, bad);
      diff_field("job_done", e.job_done, got.job_done, bad);
      if (bad != "") begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch at output %0d:%s", checked, bad);
      end
    endfunction

    function int outstanding();
      return expected_outputs.size();
    endfunction
  endclass

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [15:0]            bf16_value = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [7:0]             sign_mant;
  logic [3:0]             group;
  logic [7:0]             group_byte;
  logic                   group_byte_valid;
  logic                   escape;
  logic [15:0]            patch_column;
  logic [31:0]            patch_index;
  logic [15:0]            patch_orig;
  logic [15:0]            patch_misread;
  logic                   row_end;
  logic [31:0]            row_offset;
  logic                   job_done;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  pack_tracker sb;
  int cycles = 0;
  int sender_idle = 0;
  int stall_pct = 0;
  int cur_base = 0;

  bf16_split12_packer u_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .bf16_value       (bf16_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .sign_mant        (sign_mant),
    .group            (group),
    .group_byte       (group_byte),
    .group_byte_valid (group_byte_valid),
    .escape           (escape),
    .patch_column     (patch_column),
    .patch_index      (patch_index),
    .patch_orig       (patch_orig),
    .patch_misread    (patch_misread),
    .row_end          (row_end),
    .row_offset       (row_offset),
    .job_done         (job_done),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d outputs outstanding", cycles, sb.outstanding());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_output({sign_mant, group, group_byte, group_byte_valid, escape,
                       patch_column, patch_index, patch_orig, patch_misread,
                       row_end, row_offset, job_done});
    end
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  function automatic bf16_t make_word(logic s, int e, logic [6:0] m);
    logic [7:0] eb;
    eb = e[7:0];
    return {s, eb, m};
  endfunction

  function automatic bf16_t random_word(int b);
    int e;
    int pick;
    pick = $urandom_range(99);
    if (pick < 70) e = b + int'($urandom_range(1, GROUP_MAX));
    else if (pick < 80) e = b;
    else if (pick < 88) e = b + 16 + int'($urandom_range(20));
    else if (pick < 94) e = b - int'($urandom_range(1, 20));
    else e = int'($urandom_range(255));
    if (e < 0 || e > 255) e = int'($urandom_range(255));
    return make_word(1'($urandom_range(1)), e, 7'($urandom));
  endfunction

  // cfg_valid stays high across the three writes, lowered once at the end
  task set_job(int base, int len, int cnt);
    cfg_index_t idx [3];
    logic [15:0] val [3];
    idx = '{CFG_BASE_EXPONENT, CFG_ROW_LENGTH, CFG_ROW_COUNT};
    val = '{base[15:0], len[15:0], cnt[15:0]};
    cur_base = base;
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      sb.write_register(idx[i], val[i]);
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task send_word(bf16_t w);
    while ($urandom_range(99) < sender_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    bf16_value <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.accept_word(w);
  endtask

  task drain();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int idle_modes [4][2];
    int base;
    idle_modes = '{'{0, 0}, '{77, 0}, '{0, 77}, '{26, 26}};
    sb = new;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // odd-sized job: field extremes, group edges, escapes above and below
    set_job(100, 3, 3);
    send_word(16'h0000);
    send_word(16'hFFFF);
    send_word(make_word(1'b0, 100, 7'h7F));
    send_word(make_word(1'b0, 101, 7'h00));
    send_word(make_word(1'b1, 115, 7'h2A));
    send_word(make_word(1'b0, 116, 7'h55));
    send_word(make_word(1'b1, 99, 7'h01));
    send_word(16'h7F80);
    send_word(16'h8000);
    drain();

    // negative base, even-sized jobs
    set_job(-1, 2, 1);
    send_word(16'h0000);
    send_word(make_word(1'b0, 14, 7'h3C));
    send_word(16'hFFFF);
    send_word(make_word(1'b1, 1, 7'h40));
    drain();

    // top base; zero length and count act as one
    set_job(254, 0, 0);
    send_word(16'h7F80);
    send_word(16'h0000);
    send_word(make_word(1'b1, 254, 7'h7F));
    drain();

    // shrink the row and job limits while a job is under way
    set_job(120, 5, 4);
    send_word(make_word(1'b0, 121, 7'h11));
    send_word(make_word(1'b1, 120, 7'h22));
    send_word(make_word(1'b0, 135, 7'h33));
    drain();
    set_job(120, 2, 1);
    send_word(make_word(1'b1, 137, 7'h44));
    send_word(make_word(1'b0, 125, 7'h66));
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      sender_idle = idle_modes[phase % 4][0];
      stall_pct = idle_modes[phase % 4][1];
      base = int'($urandom_range(255)) - 1;
      case (phase)
        0: set_job(-1, $urandom_range(1, 8), $urandom_range(1, 6));
        1: set_job(254, $urandom_range(1, 8), $urandom_range(1, 6));
        2: set_job(int'($urandom_range(511)) - 256, $urandom_range(1, 8), $urandom_range(1, 8));
        3: set_job(base, 65535, 65535);
        4: set_job(base, 1, 1);
        5: set_job(base, $urandom_range(100, 300), $urandom_range(1, 3));
        default: set_job(base, $urandom_range(1, 8), $urandom_range(1, 8));
      endcase
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        if (phase == 6 && n == WORDS_PER_PHASE / 2) drain();
        send_word(random_word(cur_base));
      end
      drain();
    end

    $display("%0d words sent over %0d register writes; %0d outputs checked",
             sb.words, sb.writes, sb.checked);
    $display("%0d patches and %0d completed jobs predicted; %0d mismatches",
             sb.patches, sb.jobs, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/bsp_pkg.sv
rtl/bf16_split12_packer.sv
rtl/bsp_checker.sv
tb/bf16_split12_packer_tb.sv
